>>> rtl/core/ckse_pkg.sv
package ckse_pkg;

  localparam logic [7:0] KEY_END   = 8'h00;
  localparam logic [7:0] KEY_SIGN  = 8'h53;  // 'S'
  localparam logic [7:0] KEY_ADD   = 8'h2B;  // '+'
  localparam logic [7:0] KEY_SUB   = 8'h2D;  // '-'
  localparam logic [7:0] KEY_MUL   = 8'h2A;  // '*'
  localparam logic [7:0] KEY_DIV   = 8'h2F;  // '/'
  localparam logic [7:0] KEY_MPLUS = 8'h50;  // 'P'
  localparam logic [7:0] KEY_MMIN  = 8'h4D;  // 'M'
  localparam logic [7:0] KEY_MCLR  = 8'h43;  // 'C'
  localparam logic [7:0] KEY_MREC  = 8'h52;  // 'R'
  localparam logic [7:0] KEY_D0    = 8'h30;  // '0'
  localparam logic [7:0] KEY_D9    = 8'h39;  // '9'

  localparam int unsigned RESULT_W = 32;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } op_e;

endpackage

>>> rtl/core/calculator_key_stream_evaluator_core.sv
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i / in_stall_o   | key_code_i [7:0]
// out     | output    | out_valid_o / out_stall_i | result_value_o [31:0], signed
//
// Digits and 'S' are taken without a stall; a key inside an operator run passes
// through ST_KEY. A key that ends a number passes through ST_NEG, ST_OP, ST_KEY
// for add/sub/load, adding ST_MUL for multiply and ST_DIVB, ST_DIV, ST_DIVFIX for
// divide (no ST_DIV for a zero divisor); the shared adder runs one step a cycle.
// The end key goes on to ST_EMIT, which waits for the output register to empty.
// rst_ni is asynchronous and clears all state to zero.
// in_stall_o is high whenever the sequencer is busy; out_stall_i holds the result.
module calculator_key_stream_evaluator_core #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic [7:0]                               key_code_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic signed [ckse_pkg::RESULT_W-1:0]     result_value_o
);

  import ckse_pkg::*;

  localparam int unsigned W     = DATA_WIDTH;
  localparam int unsigned CNT_W = $clog2(DATA_WIDTH);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NEG,
    ST_OP,
    ST_MUL,
    ST_DIVB,
    ST_DIV,
    ST_DIVFIX,
    ST_KEY,
    ST_EMIT
  } state_e;

  state_e           state_q;
  logic [W-1:0]     acc_q;
  logic [W-1:0]     mem_q;
  logic [W-1:0]     num_q;
  logic             neg_q;
  op_e              op_q;
  logic             op_run_q;
  logic [7:0]       key_q;
  logic [W-1:0]     wq_q;
  logic [W-1:0]     wr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             a_neg_q;
  logic             b_neg_q;
  logic             out_valid_q;
  logic [RESULT_W-1:0] result_q;

  logic [W-1:0] add_a;
  logic [W-1:0] add_b;
  logic         add_sub;
  logic [W:0]   add_sum;
  logic [W-1:0] add_res;
  logic         add_carry;
  logic [W-1:0] div_shift;
  logic [W-1:0] digit_next;
  logic         in_xfer;
  logic         out_free;

  assign in_xfer   = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign div_shift = {wr_q[W-2:0], wq_q[W-1]};
  assign digit_next = (num_q << 3) + (num_q << 1) + W'(key_code_i[3:0]);

  // shared adder/subtractor
  assign add_sum   = {1'b0, add_a} + {1'b0, add_b ^ {W{add_sub}}} + (W+1)'(add_sub);
  assign add_res   = add_sum[W-1:0];
  assign add_carry = add_sum[W];

  always_comb begin
    add_a   = '0;
    add_b   = num_q;
    add_sub = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        add_a = '0;
      end
      ST_NEG: begin
        add_a = '0;
        add_b = num_q;
      end
      ST_OP: begin
        if (op_q == OP_DIV) begin
          add_a = '0;
          add_b = acc_q;
        end else begin
          add_a   = acc_q;
          add_b   = num_q;
          add_sub = (op_q != OP_ADD);
        end
      end
      ST_MUL: begin
        add_a   = wr_q;
        add_b   = acc_q;
        add_sub = 1'b0;
      end
      ST_DIVB: begin
        add_a = '0;
        add_b = num_q;
      end
      ST_DIV: begin
        add_a = div_shift;
        add_b = num_q;
      end
      ST_DIVFIX: begin
        add_a = '0;
        add_b = wq_q;
      end
      ST_KEY: begin
        add_a   = mem_q;
        add_b   = acc_q;
        add_sub = (key_q == KEY_MMIN);
      end
      ST_EMIT: begin
        add_a = '0;
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      mem_q       <= '0;
      num_q       <= '0;
      neg_q       <= 1'b0;
      op_q        <= OP_NONE;
      op_run_q    <= 1'b0;
      key_q       <= KEY_END;
      wq_q        <= '0;
      wr_q        <= '0;
      cnt_q       <= '0;
      a_neg_q     <= 1'b0;
      b_neg_q     <= 1'b0;
      out_valid_q <= 1'b0;
      result_q    <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != ST_EMIT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            key_q <= key_code_i;
            case (key_code_i) inside
              [KEY_D0:KEY_D9]: begin
                num_q    <= digit_next;
                op_run_q <= 1'b0;
              end
              KEY_SIGN: begin
                neg_q    <= !neg_q;
                op_run_q <= 1'b0;
              end
              default: begin
                state_q <= op_run_q ? ST_KEY : ST_NEG;
              end
            endcase
          end
        end
        ST_NEG: begin
          if (neg_q) begin
            num_q <= add_res;
          end
          state_q <= ST_OP;
        end
        ST_OP: begin
          unique case (op_q)
            OP_ADD, OP_SUB: begin
              acc_q   <= add_res;
              num_q   <= '0;
              neg_q   <= 1'b0;
              op_q    <= OP_NONE;
              state_q <= ST_KEY;
            end
            OP_MUL: begin
              wr_q    <= '0;
              cnt_q   <= CNT_W'(DATA_WIDTH - 1);
              state_q <= ST_MUL;
            end
            OP_DIV: begin
              wq_q    <= acc_q[W-1] ? add_res : acc_q;
              a_neg_q <= acc_q[W-1];
              state_q <= ST_DIVB;
            end
            default: begin
              acc_q   <= num_q;
              num_q   <= '0;
              neg_q   <= 1'b0;
              op_q    <= OP_NONE;
              state_q <= ST_KEY;
            end
          endcase
        end
        ST_MUL: begin
          if (cnt_q == '0) begin
            acc_q   <= num_q[0] ? add_res : wr_q;
            num_q   <= '0;
            neg_q   <= 1'b0;
            op_q    <= OP_NONE;
            state_q <= ST_KEY;
          end else begin
            if (num_q[0]) begin
              wr_q <= add_res;
            end
            acc_q <= acc_q << 1;
            num_q <= num_q >> 1;
            cnt_q <= cnt_q - 1'b1;
          end
        end
        ST_DIVB: begin
          b_neg_q <= num_q[W-1];
          num_q   <= num_q[W-1] ? add_res : num_q;
          wr_q    <= '0;
          cnt_q   <= CNT_W'(DATA_WIDTH - 1);
          if (num_q == '0) begin
            wq_q    <= '1;
            state_q <= ST_DIVFIX;
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (add_carry) begin
            wr_q <= add_res;
            wq_q <= {wq_q[W-2:0], 1'b1};
          end else begin
            wr_q <= div_shift;
            wq_q <= {wq_q[W-2:0], 1'b0};
          end
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= ST_DIVFIX;
          end
        end
        ST_DIVFIX: begin
          acc_q   <= (a_neg_q ^ b_neg_q) ? add_res : wq_q;
          num_q   <= '0;
          neg_q   <= 1'b0;
          op_q    <= OP_NONE;
          state_q <= ST_KEY;
        end
        ST_KEY: begin
          op_run_q <= 1'b1;
          state_q  <= (key_q == KEY_END) ? ST_EMIT : ST_IDLE;
          unique case (key_q)
            KEY_END: begin
            end
            KEY_ADD:   op_q <= OP_ADD;
            KEY_SUB:   op_q <= OP_SUB;
            KEY_MUL:   op_q <= OP_MUL;
            KEY_DIV:   op_q <= OP_DIV;
            KEY_MPLUS: mem_q <= add_res;
            KEY_MMIN:  mem_q <= add_res;
            KEY_MCLR:  mem_q <= '0;
            KEY_MREC:  acc_q <= mem_q;
            default: begin
            end
          endcase
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            result_q    <= RESULT_W'($signed(acc_q));
            acc_q       <= '0;
            mem_q       <= '0;
            num_q       <= '0;
            neg_q       <= 1'b0;
            op_q        <= OP_NONE;
            op_run_q    <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign result_value_o = $signed(result_q);

endmodule

>>> rtl/core/ckse_checker.sv
module ckse_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic [7:0]                         key_code_i,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic signed [ckse_pkg::RESULT_W-1:0] result_value_o
);

  import ckse_pkg::*;

  // held result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_value_o))
    else $error("stalled result changed");

  // no result appears in the cycle right after an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> !out_valid_o)
    else $error("result too early after input transfer");

  // a digit transfer leaves the input unstalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && key_code_i >= KEY_D0 && key_code_i <= KEY_D9
      |=> !in_stall_o)
    else $error("digit key kept input stalled");

  // a new result is loaded only while the sequencer is busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result loaded while idle");

endmodule

bind calculator_key_stream_evaluator_core ckse_checker u_ckse_checker (.*);

>>> tb/sv/calculator_key_stream_evaluator_core_test.sv
`timescale 1ns / 1ps

module calculator_key_stream_evaluator_core_test;
  import ckse_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD = 400;
  localparam int DRAIN_CYCLES = 45;

  localparam logic [7:0] DIRECTED_KEYS [25] = '{
    KEY_END,
    KEY_D9, KEY_MUL, KEY_SIGN, KEY_D9, KEY_SUB, KEY_ADD, KEY_DIV, KEY_D0, KEY_END,
    KEY_D0 + 8'd5, KEY_ADD, KEY_D0 + 8'd3, KEY_SUB, KEY_MPLUS, KEY_MCLR, KEY_MMIN,
    KEY_MREC, 8'hFF, KEY_END,
    KEY_D0 + 8'd7, KEY_SUB, KEY_SIGN, KEY_D0 + 8'd7, KEY_END
  };
  localparam logic [7:0] OPERATOR_KEYS [4] = '{KEY_ADD, KEY_SUB, KEY_MUL, KEY_DIV};
  localparam logic [7:0] MEMORY_KEYS [4] = '{KEY_MPLUS, KEY_MMIN, KEY_MCLR, KEY_MREC};

  string big_numbers [6] = '{"0", "1", "2147483647", "2147483648", "4294967295",
                             "99999999999"};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] key_code = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [RESULT_W-1:0] result_value;

  // evaluator state as seen by the predictor
  logic [31:0] calc_acc = '0;
  logic [31:0] calc_mem = '0;
  logic [31:0] calc_num = '0;
  logic calc_neg = 1'b0;
  op_e calc_op = OP_NONE;
  logic calc_in_op = 1'b0;

  logic [7:0] key_queue [$];
  logic signed [31:0] result_fifo [$];
  bit key_emits;
  logic [31:0] key_result;

  int keys_queued = 0;
  int failures = 0;
  int tx_idle_pct = 13;
  int rx_idle_pct = 48;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  calculator_key_stream_evaluator_core #(
    .DATA_WIDTH(32)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .key_code_i(key_code),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .result_value_o(result_value)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void fold_number();
    logic [31:0] n;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] q;
    n = calc_neg ? -calc_num : calc_num;
    case (calc_op)
      OP_ADD: calc_acc = calc_acc + n;
      OP_SUB: calc_acc = calc_acc - n;
      OP_MUL: calc_acc = calc_acc * n;
      OP_DIV: begin
        ma = calc_acc[31] ? -calc_acc : calc_acc;
        mb = n[31] ? -n : n;
        q = (mb == '0) ? '1 : ma / mb;
        if (calc_acc[31]) q = -q;
        if (n[31]) q = -q;
        calc_acc = q;
      end
      default: calc_acc = n;
    endcase
    calc_op = OP_NONE;
    calc_num = '0;
    calc_neg = 1'b0;
  endfunction

  function automatic void evaluate_key(input logic [7:0] k, output bit emits,
                                       output logic [31:0] value);
    emits = 1'b0;
    value = '0;
    if (k == KEY_END) begin
      if (!calc_in_op) fold_number();
      value = calc_acc;
      emits = 1'b1;
      calc_acc = '0;
      calc_mem = '0;
      calc_num = '0;
      calc_neg = 1'b0;
      calc_op = OP_NONE;
      calc_in_op = 1'b0;
    end else if ((k >= KEY_D0 && k <= KEY_D9) || k == KEY_SIGN) begin
      calc_in_op = 1'b0;
      if (k == KEY_SIGN) calc_neg = !calc_neg;
      else calc_num = calc_num * 32'd10 + {24'd0, k - KEY_D0};
    end else begin
      if (!calc_in_op) begin
        fold_number();
        calc_in_op = 1'b1;
      end
      case (k)
        KEY_ADD: calc_op = OP_ADD;
        KEY_SUB: calc_op = OP_SUB;
        KEY_MUL: calc_op = OP_MUL;
        KEY_DIV: calc_op = OP_DIV;
        KEY_MPLUS: calc_mem = calc_mem + calc_acc;
        KEY_MMIN: calc_mem = calc_mem - calc_acc;
        KEY_MCLR: calc_mem = '0;
        KEY_MREC: calc_acc = calc_mem;
        default: ;
      endcase
    end
  endfunction

  task automatic push_key(input logic [7:0] k);
    key_queue.push_back(k);
    keys_queued++;
  endtask

  task automatic push_number();
    int mode;
    int len;
    string s;
    mode = $urandom_range(9);
    if ($urandom_range(3) == 0) push_key(KEY_SIGN);
    if (mode == 8) begin
      s = big_numbers[$urandom_range(5)];
      for (int i = 0; i < s.len(); i++) push_key(s[i]);
    end else if (mode == 9) begin
      push_key(KEY_D0);
    end else begin
      len = (mode < 6) ? $urandom_range(1, 3) : $urandom_range(4, 10);
      for (int i = 0; i < len; i++) begin
        push_key(KEY_D0 + 8'($urandom_range(9)));
        if ($urandom_range(19) == 0) push_key(KEY_SIGN);
      end
    end
  endtask

  task automatic push_op_run();
    int len;
    int sel;
    logic [7:0] k;
    len = ($urandom_range(3) == 0) ? $urandom_range(2, 4) : 1;
    repeat (len) begin
      sel = $urandom_range(9);
      if (sel < 7) begin
        k = OPERATOR_KEYS[$urandom_range(3)];
      end else if (sel < 9) begin
        k = MEMORY_KEYS[$urandom_range(3)];
      end else begin
        do k = 8'($urandom_range(1, 255));
        while ((k >= KEY_D0 && k <= KEY_D9) || k == KEY_SIGN);
      end
      push_key(k);
    end
  endtask

  task automatic push_expression();
    int terms;
    if ($urandom_range(9) == 0) begin
      // noise: arbitrary bytes
      repeat ($urandom_range(1, 12)) push_key(8'($urandom_range(255)));
      push_key(KEY_END);
    end else begin
      if ($urandom_range(9) == 0) push_op_run();
      terms = $urandom_range(1, 5);
      for (int t = 0; t < terms; t++) begin
        if (t > 0) push_op_run();
        push_number();
      end
      if ($urandom_range(6) == 0) push_op_run();
      // occasionally leave the expression open so the next one runs on
      if ($urandom_range(19) != 0) push_key(KEY_END);
    end
  endtask

  task automatic push_random(input int count);
    int target;
    target = keys_queued + count;
    while (keys_queued < target) push_expression();
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (key_queue.size() != 0 || in_valid || result_fifo.size() != 0);
  endtask

  // key driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      key_code <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        evaluate_key(key_code, key_emits, key_result);
        if (key_emits) result_fifo.push_back(key_result);
      end
      if (!in_valid || !in_stall) begin
        if (key_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_valid <= 1'b1;
          key_code <= key_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD;
      hold_served <= hold_served + 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (result_fifo.size() == 0) begin
        $error("result_value: unexpected transfer, got %0d", result_value);
        failures++;
      end else begin
        if (result_value !== result_fifo[0]) begin
          $error("result_value: expected %0d, got %0d", result_fifo[0], result_value);
          failures++;
        end
        void'(result_fifo.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("calculator_key_stream_evaluator_core verification failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (DIRECTED_KEYS[i]) push_key(DIRECTED_KEYS[i]);
    wait_idle();
    push_random(600);
    wait_idle();
    tx_idle_pct = 48;
    rx_idle_pct = 13;
    push_random(600);
    wait_idle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_requests++;
    push_random(650);
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (result_fifo.size() != 0) begin
      $error("result_value: %0d results never arrived", result_fifo.size());
      failures++;
    end
    if (failures == 0) begin
      $display("calculator_key_stream_evaluator_core verification clean");
    end else begin
      $display("calculator_key_stream_evaluator_core verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/ckse_pkg.sv
rtl/core/calculator_key_stream_evaluator_core.sv
rtl/core/ckse_checker.sv
tb/sv/calculator_key_stream_evaluator_core_test.sv
